// ===== hw/rtl/exlex_pkg.sv =====
// types, constants and character codes shared by the expression lexer
`default_nettype none

package exlex_pkg;

    localparam int POS_WIDTH  = 16;
    localparam int MANT_WIDTH = 32;
    localparam int FRAC_WIDTH = 8;
    localparam int KIND_WIDTH = 4;
    localparam int MAX_TOKENS = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);
    localparam int TOK_CNT_W  = $clog2(MAX_TOKENS + 1);

    localparam logic [MANT_WIDTH-1:0] MANT_MAX = {MANT_WIDTH{1'b1}};
    localparam logic [FRAC_WIDTH-1:0] FRAC_MAX = {FRAC_WIDTH{1'b1}};

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_PLUS   = 4'd0,
        KIND_MINUS  = 4'd1,
        KIND_STAR   = 4'd2,
        KIND_SLASH  = 4'd3,
        KIND_LPAREN = 4'd4,
        KIND_RPAREN = 4'd5,
        KIND_NUMBER = 4'd6,
        KIND_IDENT  = 4'd7,
        KIND_END    = 4'd8,
        KIND_ERROR  = 4'd9
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_NUM   = 4'b0010,
        MODE_IDENT = 4'b0100,
        MODE_ERR   = 4'b1000
    } t_mode;

    typedef logic [POS_WIDTH-1:0] t_pos;

    typedef struct packed {
        logic                  seen_dot;
        logic                  seen_digit;
        logic [MANT_WIDTH-1:0] accum;
        logic [FRAC_WIDTH-1:0] frac;
        logic                  sat;
    } t_num;

    typedef struct packed {
        t_kind                 kind;
        t_pos                  start_pos;
        t_pos                  token_len;
        logic [MANT_WIDTH-1:0] mantissa;
        logic [FRAC_WIDTH-1:0] frac_digits;
        logic                  overflow;
        logic                  last_result;
    } t_token;

endpackage

`default_nettype wire

// ===== hw/rtl/exlex_if.sv =====
// character and token channel interfaces of the expression lexer
`default_nettype none

interface exlex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface exlex_token_if;
    logic                             valid;
    logic                             ready;
    logic [exlex_pkg::KIND_WIDTH-1:0] kind;
    logic [exlex_pkg::POS_WIDTH-1:0]  start_pos;
    logic [exlex_pkg::POS_WIDTH-1:0]  token_len;
    logic [exlex_pkg::MANT_WIDTH-1:0] mantissa;
    logic [exlex_pkg::FRAC_WIDTH-1:0] frac_digits;
    logic                             overflow;
    logic                             last_result;

    modport source (output valid, output kind, output start_pos, output token_len,
                    output mantissa, output frac_digits, output overflow,
                    output last_result, input ready);
    modport sink   (input valid, input kind, input start_pos, input token_len,
                    input mantissa, input frac_digits, input overflow,
                    input last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/expression_lexer_top.sv =====
// expression lexer: one character per transaction in, tokens out
//
// i_char carries one ASCII byte and a last_char flag per transaction; o_token
// carries one token per transaction (kind, start position, length, decimal
// mantissa, fraction digit count, overflow flag, last_result flag).
// each accepted character is classified and the lexer state updated in the
// same cycle; the zero to three tokens it causes are written into a four
// entry token queue, which is registered, and are presented on o_token in
// order from its head.
// a character is taken in every cycle while at most one token waits in the
// queue, so a stream of characters that cause one token or none each runs
// at one character per cycle while o_token does not stall; a character that
// causes several tokens sends them in turn, which sets the sustained rate.
// when the receiver stalls the queue fills and i_char.ready drops once two
// or more tokens wait; no token is lost or repeated.
// the character after last_char starts a new string at position zero.
// reset clears the lexer state, the position counter and the queue.
`default_nettype none

module expression_lexer_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    exlex_char_if.sink            i_char,
    exlex_token_if.source         o_token
);

    exlex_pkg::t_mode                  r_mode, n_mode;
    exlex_pkg::t_num                   r_num, n_num;
    exlex_pkg::t_pos                   r_pos, n_pos;
    exlex_pkg::t_pos                   r_start, n_start;

    exlex_pkg::t_token                 s_res [exlex_pkg::MAX_TOKENS];
    logic [exlex_pkg::TOK_CNT_W-1:0]   s_nres;

    exlex_pkg::t_token                 r_fifo [exlex_pkg::FIFO_DEPTH];
    logic [exlex_pkg::FIFO_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [exlex_pkg::CNT_WIDTH-1:0]   r_cnt, n_cnt;

    logic s_accept;
    logic s_pop;
    logic s_digit, s_alpha, s_space, s_dot;

    function automatic exlex_pkg::t_num f_add_digit(exlex_pkg::t_num num, logic [3:0] d);
        exlex_pkg::t_num                 res;
        logic [exlex_pkg::MANT_WIDTH+3:0] wide;
        res  = num;
        wide = {1'b0, num.accum, 3'b000} + {3'b000, num.accum, 1'b0}
             + {{exlex_pkg::MANT_WIDTH{1'b0}}, d};
        if (wide > {4'b0000, exlex_pkg::MANT_MAX}) begin
            res.accum = exlex_pkg::MANT_MAX;
            res.sat   = 1'b1;
        end else begin
            res.accum = wide[exlex_pkg::MANT_WIDTH-1:0];
        end
        if (num.seen_dot) begin
            if (num.frac == exlex_pkg::FRAC_MAX) begin
                res.sat = 1'b1;
            end else begin
                res.frac = num.frac + 1'b1;
            end
        end
        res.seen_digit = 1'b1;
        return res;
    endfunction

    function automatic exlex_pkg::t_token f_tok(exlex_pkg::t_kind kind, exlex_pkg::t_pos start,
                                                exlex_pkg::t_pos len);
        exlex_pkg::t_token t;
        t             = '0;
        t.kind        = kind;
        t.start_pos   = start;
        t.token_len   = len;
        return t;
    endfunction

    function automatic exlex_pkg::t_token f_finish(exlex_pkg::t_num num, exlex_pkg::t_pos start,
                                                   exlex_pkg::t_pos len);
        exlex_pkg::t_token t;
        if (num.seen_digit) begin
            t             = f_tok(exlex_pkg::KIND_NUMBER, start, len);
            t.mantissa    = num.accum;
            t.frac_digits = num.frac;
            t.overflow    = num.sat;
        end else begin
            t = f_tok(exlex_pkg::KIND_ERROR, start, len);
        end
        return t;
    endfunction

    assign s_digit = (i_char.ch >= exlex_pkg::CH_ZERO) && (i_char.ch <= exlex_pkg::CH_NINE);
    assign s_alpha = ((i_char.ch >= exlex_pkg::CH_UP_A) && (i_char.ch <= exlex_pkg::CH_UP_Z))
                  || ((i_char.ch >= exlex_pkg::CH_LO_A) && (i_char.ch <= exlex_pkg::CH_LO_Z));
    assign s_space = (i_char.ch == exlex_pkg::CH_SPACE)
                  || ((i_char.ch >= exlex_pkg::CH_TAB) && (i_char.ch <= exlex_pkg::CH_CR));
    assign s_dot   = (i_char.ch == exlex_pkg::CH_DOT);

    // per-character lexer step
    always_comb begin
        logic            v_taken;
        exlex_pkg::t_pos v_pos_inc;
        exlex_pkg::t_token v_tok;
        n_mode    = r_mode;
        n_num     = r_num;
        n_start   = r_start;
        v_taken   = 1'b0;
        v_pos_inc = r_pos + 1'b1;
        v_tok     = '0;
        s_nres    = '0;
        for (int k = 0; k < exlex_pkg::MAX_TOKENS; k++) begin
            s_res[k] = '0;
        end

        case (r_mode)
            exlex_pkg::MODE_NUM: begin
                if (s_digit) begin
                    n_num   = f_add_digit(n_num, i_char.ch[3:0]);
                    v_taken = 1'b1;
                end else if (s_dot && !n_num.seen_dot) begin
                    n_num.seen_dot = 1'b1;
                    v_taken        = 1'b1;
                end else begin
                    s_res[s_nres] = f_finish(n_num, n_start, r_pos - n_start);
                    s_nres        = s_nres + 1'b1;
                    n_mode        = n_num.seen_digit ? exlex_pkg::MODE_IDLE
                                                     : exlex_pkg::MODE_ERR;
                    n_num         = '0;
                end
            end
            exlex_pkg::MODE_IDENT: begin
                if (s_alpha) begin
                    v_taken = 1'b1;
                end else begin
                    s_res[s_nres] = f_tok(exlex_pkg::KIND_IDENT, n_start, r_pos - n_start);
                    s_nres        = s_nres + 1'b1;
                    n_mode        = exlex_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase

        if (!v_taken && n_mode == exlex_pkg::MODE_IDLE) begin
            case (i_char.ch)
                exlex_pkg::CH_PLUS:
                    v_tok = f_tok(exlex_pkg::KIND_PLUS,   r_pos, exlex_pkg::t_pos'(1));
                exlex_pkg::CH_MINUS:
                    v_tok = f_tok(exlex_pkg::KIND_MINUS,  r_pos, exlex_pkg::t_pos'(1));
                exlex_pkg::CH_STAR:
                    v_tok = f_tok(exlex_pkg::KIND_STAR,   r_pos, exlex_pkg::t_pos'(1));
                exlex_pkg::CH_SLASH:
                    v_tok = f_tok(exlex_pkg::KIND_SLASH,  r_pos, exlex_pkg::t_pos'(1));
                exlex_pkg::CH_LPAREN:
                    v_tok = f_tok(exlex_pkg::KIND_LPAREN, r_pos, exlex_pkg::t_pos'(1));
                exlex_pkg::CH_RPAREN:
                    v_tok = f_tok(exlex_pkg::KIND_RPAREN, r_pos, exlex_pkg::t_pos'(1));
                default:
                    v_tok = f_tok(exlex_pkg::KIND_ERROR,  r_pos, exlex_pkg::t_pos'(1));
            endcase
            if (v_tok.kind != exlex_pkg::KIND_ERROR) begin
                s_res[s_nres] = v_tok;
                s_nres        = s_nres + 1'b1;
            end else if (s_digit || s_dot) begin
                n_mode  = exlex_pkg::MODE_NUM;
                n_start = r_pos;
                n_num   = '0;
                if (s_digit) begin
                    n_num = f_add_digit(n_num, i_char.ch[3:0]);
                end else begin
                    n_num.seen_dot = 1'b1;
                end
            end else if (s_alpha) begin
                n_mode  = exlex_pkg::MODE_IDENT;
                n_start = r_pos;
            end else if (!s_space) begin
                s_res[s_nres] = v_tok;
                s_nres        = s_nres + 1'b1;
                n_mode        = exlex_pkg::MODE_ERR;
            end
        end

        n_pos = v_pos_inc;
        if (i_char.last_char) begin
            if (n_mode == exlex_pkg::MODE_NUM) begin
                s_res[s_nres] = f_finish(n_num, n_start, v_pos_inc - n_start);
                s_nres        = s_nres + 1'b1;
            end else if (n_mode == exlex_pkg::MODE_IDENT) begin
                s_res[s_nres] = f_tok(exlex_pkg::KIND_IDENT, n_start, v_pos_inc - n_start);
                s_nres        = s_nres + 1'b1;
            end
            s_res[s_nres] = f_tok(exlex_pkg::KIND_END, v_pos_inc, '0);
            s_nres        = s_nres + 1'b1;
            n_mode        = exlex_pkg::MODE_IDLE;
            n_num         = '0;
            n_pos         = '0;
            n_start       = '0;
        end

        if (s_nres != '0) begin
            s_res[s_nres - 1'b1].last_result = 1'b1;
        end
    end

    assign i_char.ready = (r_cnt < exlex_pkg::CNT_WIDTH'(2));
    assign s_accept     = i_char.valid && i_char.ready;
    assign s_pop        = o_token.valid && o_token.ready;

    always_comb begin
        n_cnt = r_cnt - exlex_pkg::CNT_WIDTH'(s_pop);
        if (s_accept) begin
            n_cnt = n_cnt + exlex_pkg::CNT_WIDTH'(s_nres);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= exlex_pkg::MODE_IDLE;
            r_num    <= '0;
            r_pos    <= '0;
            r_start  <= '0;
            r_cnt    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (s_accept) begin
                r_mode   <= n_mode;
                r_num    <= n_num;
                r_pos    <= n_pos;
                r_start  <= n_start;
                r_wr_ptr <= r_wr_ptr + exlex_pkg::FIFO_AW'(s_nres);
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int k = 0; k < exlex_pkg::MAX_TOKENS; k++) begin
                if (k < int'(s_nres)) begin
                    r_fifo[r_wr_ptr + exlex_pkg::FIFO_AW'(k)] <= s_res[k];
                end
            end
        end
    end

    assign o_token.valid       = (r_cnt != '0);
    assign o_token.kind        = r_fifo[r_rd_ptr].kind;
    assign o_token.start_pos   = r_fifo[r_rd_ptr].start_pos;
    assign o_token.token_len   = r_fifo[r_rd_ptr].token_len;
    assign o_token.mantissa    = r_fifo[r_rd_ptr].mantissa;
    assign o_token.frac_digits = r_fifo[r_rd_ptr].frac_digits;
    assign o_token.overflow    = r_fifo[r_rd_ptr].overflow;
    assign o_token.last_result = r_fifo[r_rd_ptr].last_result;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= exlex_pkg::CNT_WIDTH'(exlex_pkg::FIFO_DEPTH))
        else $error("token queue count out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cnt == '0) && (r_pos == '0))
        else $error("queue or position not cleared by reset");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && o_token.kind == exlex_pkg::KIND_END) |-> o_token.last_result)
        else $error("end token without last_result");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_char.last_char) |=> (r_pos == '0) && (r_mode == exlex_pkg::MODE_IDLE))
        else $error("string end did not restart the lexer");

    a_non_number_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && o_token.kind != exlex_pkg::KIND_NUMBER)
            |-> (o_token.mantissa == '0) && !o_token.overflow
                && (o_token.frac_digits == '0))
        else $error("number fields set on a non-number token");
`endif

endmodule

`default_nettype wire
